// ===== design/dfs_maze_carver_top_assert.svh =====
// Assertion helpers for the maze carver
`ifndef DFS_MAZE_CARVER_TOP_ASSERT_SVH
`define DFS_MAZE_CARVER_TOP_ASSERT_SVH
`define DMC_ASSERT_IMPL(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
`define DMC_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`endif

// ===== design/dmc_pkg.sv =====
package dmc_pkg;
   localparam int MAZE_ROWS_DEF   = 31;
   localparam int MAZE_COLS_DEF   = 31;
   localparam int STACK_DEPTH_DEF = 225;
   localparam int COORD_W = 6;

   localparam logic [1:0] ACT_START = 2'd0;
   localparam logic [1:0] ACT_DRAW  = 2'd1;
   localparam logic [1:0] ACT_READ  = 2'd2;

   localparam logic [1:0] KIND_WALL = 2'd0;
   localparam logic [1:0] KIND_PATH = 2'd1;
   localparam logic [1:0] KIND_GOAL = 2'd2;

   localparam logic [1:0] DIR_UP    = 2'd0;
   localparam logic [1:0] DIR_DOWN  = 2'd1;
   localparam logic [1:0] DIR_LEFT  = 2'd2;
   localparam logic [1:0] DIR_RIGHT = 2'd3;

   localparam logic [7:0] ORDER_INIT = 8'hE4;

   localparam logic CSR_GOAL_ROW = 1'b0;
   localparam logic CSR_GOAL_COL = 1'b1;

   typedef struct packed {
      logic [1:0] action;
      logic [1:0] draw;
      logic [5:0] cell_row;
      logic [5:0] cell_col;
   } req_type;

   typedef struct packed {
      logic [5:0] out_row;
      logic [5:0] out_col;
      logic [1:0] tile;
      logic       is_read;
      logic       finished;
      logic       last;
   } rsp_type;

   // frame: row, col, order, idx (idx 0..4)
   typedef struct packed {
      logic [5:0] row;
      logic [5:0] col;
      logic [7:0] order;
      logic [2:0] idx;
   } frame_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_CLEAR,
      ST_START,
      ST_READ,
      ST_READ_WAIT,
      ST_FRAME_RD,
      ST_FRAME_WAIT,
      ST_TRY,
      ST_VIS_WAIT,
      ST_CARVE_WALL,
      ST_CARVE_CELL,
      ST_GOAL_CELL,
      ST_GOAL_TILE,
      ST_OUT
   } state_type;
endpackage

// ===== design/dmc_ram.sv =====
module dmc_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;
endmodule

// ===== design/dfs_maze_carver_top.sv =====
// Depth-first (recursive backtracker) maze carver. After reset the block runs a clearing
// pass over all MAZE_ROWS*MAZE_COLS cells (961 by default) that walls the tile memory and
// clears the visited memory one cell a cycle; no request is taken meanwhile. A start request
// runs the same pass and then carves (1,1). Draw requests feed one random slot index each;
// a draw that only advances the shuffle gives no result. Every fourth draw of a frame runs
// the carver, which walks the frame stack through registered-read memories: a direction
// whose target is off the grid (or would overflow the stack) is skipped at the try step,
// one inside the grid goes through try, visited read and decide, each pop reads the frame
// below back in, and a carve makes two tile writes, wall then cell. Reads fetch the tile
// through the registered read port. Results (none, one or two per request) leave through a
// registered output stage; the block takes no new request until the last result of the
// current one has been taken.
module dfs_maze_carver_top #(
   parameter int MAZE_ROWS   = dmc_pkg::MAZE_ROWS_DEF,
   parameter int MAZE_COLS   = dmc_pkg::MAZE_COLS_DEF,
   parameter int STACK_DEPTH = dmc_pkg::STACK_DEPTH_DEF
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  dmc_pkg::req_type   req_data,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output dmc_pkg::rsp_type   rsp_data,
   input  logic               csr_we,
   input  logic               csr_index,
   input  logic [5:0]         csr_wdata
);
   import dmc_pkg::*;
   `include "dfs_maze_carver_top_assert.svh"

   localparam int CELLS = MAZE_ROWS * MAZE_COLS;
   localparam int AW    = $clog2(CELLS);
   localparam int SW    = $clog2(STACK_DEPTH + 1);
   localparam int SAW   = $clog2(STACK_DEPTH);
   localparam int FW    = $bits(frame_type);

   // config
   logic [5:0] goal_row_ff, goal_col_ff;
   always_ff @(posedge clock) begin
      if (reset) begin
         goal_row_ff <= 6'd29;
         goal_col_ff <= 6'd29;
      end else if (csr_we) begin
         case (csr_index)
            CSR_GOAL_ROW: goal_row_ff <= csr_wdata;
            CSR_GOAL_COL: goal_col_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   // state
   state_type  state_ff, state_in;
   logic [SW-1:0] level_ff, level_in;
   logic [1:0] shuf_ff, shuf_in;
   logic [7:0] order_ff, order_in;
   logic       gen_ff, gen_in;
   logic       boot_ff, boot_in;
   logic [AW-1:0] clr_ff, clr_in;
   frame_type  frame_ff, frame_in;
   logic [5:0] nr_ff, nr_in, nc_ff, nc_in;
   rsp_type    out0_ff, out0_in, out1_ff, out1_in;
   logic       two_ff, two_in;
   logic       rsp_valid_ff, rsp_valid_in;
   logic       second_ff, second_in;
   logic [5:0] rd_row_ff, rd_row_in, rd_col_ff, rd_col_in;
   logic       rd_in_ff, rd_in_in;

   // memories
   logic          t_we, v_we, f_we;
   logic [AW-1:0] t_waddr, t_raddr, v_waddr, v_raddr;
   logic [1:0]    t_wdata, t_rdata;
   logic [0:0]    v_wdata, v_rdata;
   logic [SAW-1:0] f_waddr, f_raddr;
   logic [FW-1:0] f_wdata, f_rdata;

   dmc_ram #(.WIDTH(2), .DEPTH(CELLS)) u_tile (
      .clock, .wr_en(t_we), .wr_addr(t_waddr), .wr_data(t_wdata),
      .rd_addr(t_raddr), .rd_data(t_rdata));
   dmc_ram #(.WIDTH(1), .DEPTH(CELLS)) u_visit (
      .clock, .wr_en(v_we), .wr_addr(v_waddr), .wr_data(v_wdata),
      .rd_addr(v_raddr), .rd_data(v_rdata));
   dmc_ram #(.WIDTH(FW), .DEPTH(STACK_DEPTH)) u_stack (
      .clock, .wr_en(f_we), .wr_addr(f_waddr), .wr_data(f_wdata),
      .rd_addr(f_raddr), .rd_data(f_rdata));

   // address function: multiply-add row*COLS+col, used at each memory port
   function automatic logic [AW-1:0] cell_addr(input logic [5:0] r, input logic [5:0] c);
      logic [12:0] s;
      s = 13'(r) * 13'(MAZE_COLS) + 13'(c);
      return s[AW-1:0];
   endfunction

   // swap for the shuffle
   logic [1:0] slot_a, slot_b;
   logic [7:0] swapped;
   always_comb begin
      slot_a  = order_ff[2*shuf_ff +: 2];
      slot_b  = order_ff[2*req_data.draw +: 2];
      swapped = order_ff;
      swapped[2*shuf_ff +: 2] = slot_b;
      swapped[2*req_data.draw +: 2] = slot_a;
   end

   // direction target of the current frame
   logic [1:0] dir;
   logic [6:0] tr, tc;
   logic       t_ok;
   always_comb begin
      dir = frame_ff.order[2*frame_ff.idx[1:0] +: 2];
      tr  = {1'b0, frame_ff.row};
      tc  = {1'b0, frame_ff.col};
      case (dir)
         DIR_UP:    tr = {1'b0, frame_ff.row} - 7'd2;
         DIR_DOWN:  tr = {1'b0, frame_ff.row} + 7'd2;
         DIR_LEFT:  tc = {1'b0, frame_ff.col} - 7'd2;
         DIR_RIGHT: tc = {1'b0, frame_ff.col} + 7'd2;
         default: ;
      endcase
      // negative wraps to >= 64, caught by the upper bound
      t_ok = (tr != 7'd0) && (tr < 7'(MAZE_ROWS - 1)) &&
             (tc != 7'd0) && (tc < 7'(MAZE_COLS - 1));
   end

   logic req_fire, rsp_fire;
   assign req_fire = req_valid && req_ready;
   assign rsp_fire = rsp_valid_ff && rsp_ready;
   assign req_ready = (state_ff == ST_IDLE) && !rsp_valid_ff;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = second_ff ? out1_ff : out0_ff;

   always_comb begin
      state_in = state_ff;
      level_in = level_ff;
      shuf_in  = shuf_ff;
      order_in = order_ff;
      gen_in   = gen_ff;
      boot_in  = boot_ff;
      clr_in   = clr_ff;
      frame_in = frame_ff;
      nr_in    = nr_ff;
      nc_in    = nc_ff;
      out0_in  = out0_ff;
      out1_in  = out1_ff;
      two_in   = two_ff;
      rsp_valid_in = rsp_valid_ff;
      second_in = second_ff;
      rd_row_in = rd_row_ff;
      rd_col_in = rd_col_ff;
      rd_in_in  = rd_in_ff;
      t_we = 1'b0; t_waddr = '0; t_wdata = KIND_WALL;
      v_we = 1'b0; v_waddr = '0; v_wdata = 1'b0;
      f_we = 1'b0; f_waddr = '0; f_wdata = '0;
      t_raddr = cell_addr(rd_row_ff, rd_col_ff);
      v_raddr = cell_addr(nr_ff, nc_ff);
      f_raddr = SAW'(level_ff - SW'(1));

      if (rsp_fire) begin
         if (two_ff && !second_ff) begin
            second_in = 1'b1;
         end else begin
            rsp_valid_in = 1'b0;
            second_in = 1'b0;
         end
      end

      case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               case (req_data.action)
                  ACT_START: begin
                     clr_in = '0;
                     gen_in = 1'b0;
                     state_in = ST_CLEAR;
                  end
                  ACT_READ: begin
                     rd_row_in = req_data.cell_row;
                     rd_col_in = req_data.cell_col;
                     rd_in_in  = (req_data.cell_row < 6'(MAZE_ROWS)) &&
                                 (req_data.cell_col < 6'(MAZE_COLS));
                     state_in = ST_READ;
                  end
                  ACT_DRAW: begin
                     if (gen_ff) begin
                        order_in = swapped;
                        if (shuf_ff != 2'd3) begin
                           shuf_in = shuf_ff + 2'd1;
                        end else begin
                           shuf_in = 2'd0;
                           // top frame takes the new order, idx 0
                           frame_in.order = swapped;
                           frame_in.idx = '0;
                           f_we = 1'b1;
                           f_waddr = SAW'(level_ff - SW'(1));
                           f_wdata = {frame_ff.row, frame_ff.col, swapped, 3'd0};
                           state_in = ST_TRY;
                        end
                     end
                  end
                  default: ;
               endcase
            end
         end
         ST_CLEAR: begin
            t_we = 1'b1; t_waddr = clr_ff; t_wdata = KIND_WALL;
            v_we = 1'b1; v_waddr = clr_ff; v_wdata = 1'b0;
            clr_in = clr_ff + AW'(1);
            if (clr_ff == AW'(CELLS - 1)) begin
               // the pass after reset only clears; a start request goes on to carve
               state_in = boot_ff ? ST_IDLE : ST_START;
               boot_in = 1'b0;
            end
         end
         ST_START: begin
            t_we = 1'b1; t_waddr = cell_addr(6'd1, 6'd1); t_wdata = KIND_PATH;
            v_we = 1'b1; v_waddr = cell_addr(6'd1, 6'd1); v_wdata = 1'b1;
            f_we = 1'b1; f_waddr = '0;
            f_wdata = {6'd1, 6'd1, ORDER_INIT, 3'd0};
            frame_in = '{row: 6'd1, col: 6'd1, order: ORDER_INIT, idx: 3'd0};
            level_in = SW'(1);
            shuf_in = 2'd0;
            order_in = ORDER_INIT;
            gen_in = 1'b1;
            out0_in = '{out_row: 6'd1, out_col: 6'd1, tile: KIND_PATH,
                        is_read: 1'b0, finished: 1'b0, last: 1'b1};
            two_in = 1'b0;
            state_in = ST_OUT;
         end
         ST_READ: begin
            // tile address sits on the read port this cycle
            two_in = 1'b0;
            out0_in = '{out_row: rd_row_ff, out_col: rd_col_ff, tile: KIND_WALL,
                        is_read: 1'b1, finished: 1'b0, last: 1'b1};
            state_in = ST_READ_WAIT;
         end
         ST_READ_WAIT: begin
            out0_in.tile = rd_in_ff ? t_rdata : KIND_WALL;
            state_in = ST_OUT;
         end
         ST_FRAME_RD: begin
            state_in = ST_FRAME_WAIT;
         end
         ST_FRAME_WAIT: begin
            frame_in = frame_type'(f_rdata);
            state_in = ST_TRY;
         end
         ST_TRY: begin
            if (level_ff == '0) begin
               state_in = ST_GOAL_CELL;
            end else if (frame_ff.idx[2]) begin
               level_in = level_ff - SW'(1);
               state_in = (level_ff == SW'(1)) ? ST_GOAL_CELL : ST_FRAME_RD;
            end else begin
               frame_in.idx = frame_ff.idx + 3'd1;
               f_we = 1'b1;
               f_waddr = SAW'(level_ff - SW'(1));
               f_wdata = {frame_ff.row, frame_ff.col, frame_ff.order, frame_ff.idx + 3'd1};
               if (t_ok && level_ff < SW'(STACK_DEPTH)) begin
                  nr_in = tr[5:0];
                  nc_in = tc[5:0];
                  state_in = ST_VIS_WAIT;
               end
            end
         end
         ST_VIS_WAIT: begin
            state_in = ST_CARVE_WALL;
         end
         ST_CARVE_WALL: begin
            if (v_rdata[0]) begin
               state_in = ST_TRY;
            end else begin
               t_we = 1'b1;
               t_waddr = cell_addr(6'((7'(frame_ff.row) + 7'(nr_ff)) >> 1),
                                   6'((7'(frame_ff.col) + 7'(nc_ff)) >> 1));
               t_wdata = KIND_PATH;
               v_we = 1'b1; v_waddr = cell_addr(nr_ff, nc_ff); v_wdata = 1'b1;
               out0_in = '{out_row: 6'((7'(frame_ff.row) + 7'(nr_ff)) >> 1),
                           out_col: 6'((7'(frame_ff.col) + 7'(nc_ff)) >> 1),
                           tile: KIND_PATH, is_read: 1'b0, finished: 1'b0, last: 1'b0};
               state_in = ST_CARVE_CELL;
            end
         end
         ST_CARVE_CELL: begin
            t_we = 1'b1; t_waddr = cell_addr(nr_ff, nc_ff); t_wdata = KIND_PATH;
            f_we = 1'b1; f_waddr = SAW'(level_ff);
            f_wdata = {nr_ff, nc_ff, ORDER_INIT, 3'd0};
            frame_in = '{row: nr_ff, col: nc_ff, order: ORDER_INIT, idx: 3'd0};
            level_in = level_ff + SW'(1);
            order_in = ORDER_INIT;
            out1_in = '{out_row: nr_ff, out_col: nc_ff, tile: KIND_PATH,
                        is_read: 1'b0, finished: 1'b0, last: 1'b1};
            two_in = 1'b1;
            state_in = ST_OUT;
         end
         ST_GOAL_CELL: begin
            level_in = '0;
            if (goal_row_ff < 6'(MAZE_ROWS) && goal_col_ff < 6'(MAZE_COLS)) begin
               t_we = 1'b1; t_waddr = cell_addr(goal_row_ff, goal_col_ff);
               t_wdata = KIND_PATH;
            end
            out0_in = '{out_row: goal_row_ff, out_col: goal_col_ff, tile: KIND_PATH,
                        is_read: 1'b0, finished: 1'b1, last: 1'b0};
            state_in = ST_GOAL_TILE;
         end
         ST_GOAL_TILE: begin
            if (goal_row_ff < 6'(MAZE_ROWS)) begin
               t_we = 1'b1; t_waddr = cell_addr(goal_row_ff, 6'(MAZE_COLS - 1));
               t_wdata = KIND_GOAL;
            end
            gen_in = 1'b0;
            order_in = ORDER_INIT;
            out1_in = '{out_row: goal_row_ff, out_col: 6'(MAZE_COLS - 1), tile: KIND_GOAL,
                        is_read: 1'b0, finished: 1'b1, last: 1'b1};
            two_in = 1'b1;
            state_in = ST_OUT;
         end
         ST_OUT: begin
            rsp_valid_in = 1'b1;
            second_in = 1'b0;
            state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
         boot_ff  <= 1'b1;
         clr_ff   <= '0;
         level_ff <= '0;
         shuf_ff  <= '0;
         order_ff <= ORDER_INIT;
         gen_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
         second_ff <= 1'b0;
         two_ff   <= 1'b0;
      end else begin
         state_ff <= state_in;
         boot_ff  <= boot_in;
         clr_ff   <= clr_in;
         level_ff <= level_in;
         shuf_ff  <= shuf_in;
         order_ff <= order_in;
         gen_ff   <= gen_in;
         rsp_valid_ff <= rsp_valid_in;
         second_ff <= second_in;
         two_ff   <= two_in;
      end
   end

   always_ff @(posedge clock) begin
      frame_ff  <= frame_in;
      nr_ff     <= nr_in;
      nc_ff     <= nc_in;
      out0_ff   <= out0_in;
      out1_ff   <= out1_in;
      rd_row_ff <= rd_row_in;
      rd_col_ff <= rd_col_in;
      rd_in_ff  <= rd_in_in;
   end

   `DMC_ASSERT_IMPL(a_no_accept_busy, clock, reset, req_fire, !rsp_valid_ff,
      "request accepted while a result waits")
   `DMC_ASSERT_IMPL(a_level_bound, clock, reset, 1'b1, level_ff <= SW'(STACK_DEPTH),
      "stack level beyond depth")
   `DMC_ASSERT_NEXT(a_second_last, clock, reset, rsp_fire && two_ff && !second_ff,
      rsp_valid && rsp_data.last, "second result missing")
endmodule

// ===== sim/dfs_maze_carver_checker.sv =====
`timescale 1ns / 1ps

module dfs_maze_carver_checker (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   input  logic    req_ready,
   input  dmc_pkg::req_type req_data,
   input  logic    rsp_valid,
   input  logic    rsp_ready,
   input  dmc_pkg::rsp_type rsp_data,
   input  logic    csr_we,
   input  logic    csr_index,
   input  logic [5:0] csr_wdata,
   output int      fail_count,
   output int      pending
);
   import dmc_pkg::*;

   localparam int ROWS  = MAZE_ROWS_DEF;
   localparam int COLS  = MAZE_COLS_DEF;
   localparam int DEPTH = STACK_DEPTH_DEF;

   logic [1:0] tile_mem [ROWS*COLS];
   logic       seen_mem [ROWS*COLS];
   frame_type  frames [DEPTH];
   int         level;
   int         shuffle_pos;
   logic [7:0] dir_order;
   logic       carving;
   logic [5:0] goal_row, goal_col;

   rsp_type    carve_queue [$];

   assign pending = carve_queue.size();

   function automatic rsp_type mk(int r, int c, logic [1:0] t, logic rd, logic fin,
                                  logic lst);
      rsp_type x;
      x.out_row  = r[5:0];
      x.out_col  = c[5:0];
      x.tile     = t;
      x.is_read  = rd;
      x.finished = fin;
      x.last     = lst;
      return x;
   endfunction

   task automatic wipe_grid();
      for (int i = 0; i < ROWS*COLS; i++) begin
         tile_mem[i] = KIND_WALL;
         seen_mem[i] = 1'b0;
      end
   endtask

   // depth-first step, run on the fourth draw of a frame
   task automatic carve_from_top();
      frame_type  fr;
      logic [1:0] d;
      int r, c, nr, nc, wr, wc;
      while (level > 0) begin
         fr = frames[level-1];
         if (fr.idx >= 3'd4) begin
            level--;
            continue;
         end
         d = fr.order[2*fr.idx[1:0] +: 2];
         frames[level-1].idx = fr.idx + 3'd1;
         r = fr.row;
         c = fr.col;
         nr = r;
         nc = c;
         if (d == DIR_UP)    nr = r - 2;
         if (d == DIR_DOWN)  nr = r + 2;
         if (d == DIR_LEFT)  nc = c - 2;
         if (d == DIR_RIGHT) nc = c + 2;
         if (nr <= 0 || nr >= ROWS-1 || nc <= 0 || nc >= COLS-1) continue;
         if (seen_mem[nr*COLS+nc]) continue;
         if (level >= DEPTH) continue;
         wr = (r + nr) / 2;
         wc = (c + nc) / 2;
         tile_mem[wr*COLS+wc] = KIND_PATH;
         seen_mem[nr*COLS+nc] = 1'b1;
         tile_mem[nr*COLS+nc] = KIND_PATH;
         frames[level] = '{row: nr[5:0], col: nc[5:0], order: ORDER_INIT, idx: 3'd0};
         level++;
         dir_order = ORDER_INIT;
         carve_queue.push_back(mk(wr, wc, KIND_PATH, 0, 0, 0));
         carve_queue.push_back(mk(nr, nc, KIND_PATH, 0, 0, 1));
         return;
      end
      // stack empty: open the goal; off-grid writes are dropped
      if (goal_row < ROWS && goal_col < COLS) tile_mem[goal_row*COLS+goal_col] = KIND_PATH;
      if (goal_row < ROWS) tile_mem[goal_row*COLS+COLS-1] = KIND_GOAL;
      carving = 1'b0;
      dir_order = ORDER_INIT;
      carve_queue.push_back(mk(goal_row, goal_col, KIND_PATH, 0, 1, 0));
      carve_queue.push_back(mk(goal_row, COLS-1, KIND_GOAL, 0, 1, 1));
   endtask

   task automatic take_request(req_type q);
      logic [1:0] a, b, t;
      case (q.action)
         ACT_START: begin
            wipe_grid();
            seen_mem[COLS+1] = 1'b1;
            tile_mem[COLS+1] = KIND_PATH;
            frames[0] = '{row: 6'd1, col: 6'd1, order: ORDER_INIT, idx: 3'd0};
            level = 1;
            shuffle_pos = 0;
            dir_order = ORDER_INIT;
            carving = 1'b1;
            carve_queue.push_back(mk(1, 1, KIND_PATH, 0, 0, 1));
         end
         ACT_READ: begin
            t = KIND_WALL;
            if (q.cell_row < ROWS && q.cell_col < COLS)
               t = tile_mem[q.cell_row*COLS+q.cell_col];
            carve_queue.push_back(mk(q.cell_row, q.cell_col, t, 1, 0, 1));
         end
         ACT_DRAW: begin
            if (carving) begin
               a = dir_order[2*shuffle_pos +: 2];
               b = dir_order[2*q.draw +: 2];
               dir_order[2*shuffle_pos +: 2] = b;
               dir_order[2*q.draw +: 2] = a;
               if (shuffle_pos < 3) begin
                  shuffle_pos++;
               end else begin
                  shuffle_pos = 0;
                  if (level > 0) begin
                     frames[level-1].order = dir_order;
                     frames[level-1].idx = 3'd0;
                  end
                  carve_from_top();
               end
            end
         end
         default: ;
      endcase
   endtask

   task automatic check_field(string name, int exp_v, int act_v);
      if (exp_v != act_v) begin
         $error("%s: expected %0d, got %0d", name, exp_v, act_v);
         fail_count++;
      end
   endtask

   always @(posedge clock) begin
      rsp_type e;
      if (reset) begin
         wipe_grid();
         level = 0;
         shuffle_pos = 0;
         dir_order = ORDER_INIT;
         carving = 1'b0;
         goal_row = 6'd29;
         goal_col = 6'd29;
         fail_count = 0;
         carve_queue.delete();
      end else begin
         // older results first, then predictions for a newly taken request
         if (rsp_valid && rsp_ready) begin
            if (carve_queue.size() == 0) begin
               $error("unexpected result row %0d col %0d", rsp_data.out_row,
                      rsp_data.out_col);
               fail_count++;
            end else begin
               e = carve_queue.pop_front();
               check_field("out_row", e.out_row, rsp_data.out_row);
               check_field("out_col", e.out_col, rsp_data.out_col);
               check_field("tile", e.tile, rsp_data.tile);
               check_field("is_read", e.is_read, rsp_data.is_read);
               check_field("finished", e.finished, rsp_data.finished);
               check_field("last", e.last, rsp_data.last);
            end
         end
         if (req_valid && req_ready) take_request(req_data);
         if (csr_we) begin
            if (csr_index == CSR_GOAL_ROW) goal_row = csr_wdata;
            else goal_col = csr_wdata;
         end
      end
   end
endmodule

// ===== sim/tb_dfs_maze_carver_top.sv =====
`timescale 1ns / 1ps

module tb_dfs_maze_carver_top;
   import dmc_pkg::*;

   // no-progress limit: the clearing sweep, long pop chains and the
   // long receiver hold-off all fit well inside this
   localparam int STALL_LIMIT  = 20000;
   localparam int HOLD_CYCLES  = 400;
   localparam int PHASE_ITEMS  = 470;

   logic    clock;
   logic    reset;
   logic    req_valid;
   logic    req_ready;
   req_type req_data;
   logic    rsp_valid;
   logic    rsp_ready;
   rsp_type rsp_data;
   logic    csr_we;
   logic    csr_index;
   logic [5:0] csr_wdata;

   int fail_count;
   int pending;

   // idling knobs, percent of cycles
   int send_idle_pct;
   int recv_stall_pct;
   // hold-off handshake between stimulus and receiver process
   int hold_asked;
   int hold_taken;
   int hold_left;
   int quiet_cycles;

   dfs_maze_carver_top u_top (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   dfs_maze_carver_checker u_checker (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_ready  (req_ready),
      .req_data   (req_data),
      .rsp_valid  (rsp_valid),
      .rsp_ready  (rsp_ready),
      .rsp_data   (rsp_data),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .fail_count (fail_count),
      .pending    (pending)
   );

   // 10 ns clock
   initial clock = 1'b0;
   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // receiver: random stalls, plus a long hold-off when asked so the block
   // backs up and stops taking requests
   always @(negedge clock) begin
      if (hold_asked != hold_taken) begin
         hold_taken = hold_asked;
         hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= ($urandom_range(99) >= recv_stall_pct);
      end
   end

   // watchdog: cycles with no handshake on either channel
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= STALL_LIMIT) begin
         $display("FAIL");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   // called at a falling edge; returns at the falling edge after acceptance.
   // valid is left high so back-to-back requests need no second assignment
   task automatic send(req_type r);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= r;
      do @(posedge clock); while (!req_ready);
      @(negedge clock);
   endtask

   function automatic req_type mk_req(logic [1:0] act, logic [1:0] d, logic [5:0] r,
                                      logic [5:0] c);
      req_type x;
      x.action   = act;
      x.draw     = d;
      x.cell_row = r;
      x.cell_col = c;
      return x;
   endfunction

   // drain and settle, then write both goal registers
   task automatic set_goal(logic [5:0] grow, logic [5:0] gcol);
      req_valid <= 1'b0;
      while (pending != 0) @(negedge clock);
      repeat (100) @(negedge clock);
      csr_we    <= 1'b1;
      csr_index <= CSR_GOAL_ROW;
      csr_wdata <= grow;
      @(negedge clock);
      csr_index <= CSR_GOAL_COL;
      csr_wdata <= gcol;
      @(negedge clock);
      csr_we    <= 1'b0;
   endtask

   // mostly draws into a live maze, with reads, noise and the odd restart
   task automatic random_phase(int n);
      int roll;
      logic [5:0] r, c;
      for (int i = 0; i < n; i++) begin
         roll = $urandom_range(999);
         r = 6'($urandom_range(63));
         c = 6'($urandom_range(63));
         if (roll < 3) begin
            send(mk_req(ACT_START, 2'($urandom_range(3)), r, c));
         end else if (roll < 80) begin
            if (roll < 50) begin
               r = 6'($urandom_range(30));
               c = 6'($urandom_range(30));
            end
            send(mk_req(ACT_READ, 2'($urandom_range(3)), r, c));
         end else if (roll < 100) begin
            send(mk_req(2'd3, 2'($urandom_range(3)), r, c));
         end else begin
            send(mk_req(ACT_DRAW, 2'($urandom_range(3)), r, c));
         end
      end
   endtask

   initial begin
      reset = 1'b1;
      req_valid = 1'b0;
      req_data = '0;
      csr_we = 1'b0;
      csr_index = CSR_GOAL_ROW;
      csr_wdata = '0;
      rsp_ready = 1'b0;
      send_idle_pct = 0;
      recv_stall_pct = 0;
      hold_asked = 0;
      hold_taken = 0;
      hold_left = 0;
      quiet_cycles = 0;
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // directed: ignored items before any start, reads at the corners
      send(mk_req(ACT_DRAW, 2'd3, 6'd0, 6'd0));
      send(mk_req(2'd3, 2'd0, 6'd63, 6'd63));
      send(mk_req(ACT_READ, 2'd0, 6'd0, 6'd0));
      send(mk_req(ACT_READ, 2'd3, 6'd63, 6'd63));
      send(mk_req(ACT_READ, 2'd0, 6'd30, 6'd30));
      send(mk_req(ACT_START, 2'd0, 6'd0, 6'd0));
      send(mk_req(ACT_READ, 2'd0, 6'd1, 6'd1));
      // restart while generating
      send(mk_req(ACT_START, 2'd3, 6'd63, 6'd0));
      // shuffles with every draw value, each fourth draw carves
      for (int k = 0; k < 4; k++) send(mk_req(ACT_DRAW, k[1:0], 6'd0, 6'd63));
      for (int k = 0; k < 4; k++) send(mk_req(ACT_DRAW, 2'd3, 6'd63, 6'd0));
      send(mk_req(2'd3, 2'd1, 6'd1, 6'd1));
      send(mk_req(ACT_READ, 2'd1, 6'd62, 6'd0));
      send(mk_req(ACT_READ, 2'd2, 6'd0, 6'd62));
      send(mk_req(ACT_READ, 2'd0, 6'd1, 6'd2));

      // phase 1: no idling, goal at extremes, one long hold-off
      set_goal(6'd62, 6'd0);
      send_idle_pct = 0;
      recv_stall_pct = 0;
      hold_asked++;
      random_phase(PHASE_ITEMS);

      // phase 2: sender mostly idle
      set_goal(6'd0, 6'd62);
      send_idle_pct = 87;
      recv_stall_pct = 0;
      random_phase(PHASE_ITEMS);

      // phase 3: receiver mostly stalled; goal off the grid
      set_goal(6'd40, 6'd45);
      send_idle_pct = 0;
      recv_stall_pct = 87;
      random_phase(PHASE_ITEMS);

      // phase 4: both sides idle a third of the time
      set_goal(6'($urandom_range(63)), 6'($urandom_range(63)));
      send_idle_pct = 33;
      recv_stall_pct = 33;
      random_phase(PHASE_ITEMS);

      req_valid <= 1'b0;
      while (pending != 0) @(posedge clock);
      repeat (100) @(posedge clock);
      if (fail_count == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end
endmodule
